@@ design/rrts_pkg.sv @@
// Shared types and constants of the round robin thread scheduler.
package rrts_pkg;

   localparam int MAX_THREADS = 8;
   localparam int SLOT_W      = $clog2(MAX_THREADS);
   localparam int CNT_W       = $clog2(MAX_THREADS + 1);
   localparam int ID_W        = 8;
   localparam int ADDR_W      = 16;
   localparam int QU_W        = 16;

   localparam logic [QU_W-1:0] QUANTUM_RESET = 16'd100;

   // Thread call codes carried by a request beat.
   localparam logic [2:0] OP_CREATE = 3'd1;
   localparam logic [2:0] OP_EXIT   = 3'd2;
   localparam logic [2:0] OP_JOIN   = 3'd3;
   localparam logic [2:0] OP_YIELD  = 3'd4;

   // Thread status codes held in each slot.
   localparam logic [1:0] STATUS_READY   = 2'd0;
   localparam logic [1:0] STATUS_RUNNING = 2'd1;
   localparam logic [1:0] STATUS_BLOCKED = 2'd2;

   typedef struct packed {
      logic [2:0]        operation;
      logic              halted;
      logic [7:0]        step_cycles;
      logic [ADDR_W-1:0] start_address;
      logic [ID_W-1:0]   target_id;
   } rrts_req_type;

   typedef struct packed {
      logic              switched;
      logic [2:0]        save_slot;
      logic [2:0]        restore_slot;
      logic              fresh_start;
      logic [ADDR_W-1:0] entry_address;
      logic [ID_W-1:0]   created_id;
      logic              all_finished;
      logic [3:0]        live_threads;
   } rrts_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        status;
      logic [ID_W-1:0]   ident;
      logic [ADDR_W-1:0] entry;
      logic              started;
      logic [ID_W-1:0]   waits_for;
   } rrts_slot_type;

   // Effects of the thread call, applied before the switch decision.
   typedef struct packed {
      logic              finish;
      logic              block;
      logic              create;
      logic [SLOT_W-1:0] run_idx;
      logic [ID_W-1:0]   finish_id;
      logic [ID_W-1:0]   target;
      logic [SLOT_W-1:0] new_idx;
      logic [ID_W-1:0]   new_ident;
      logic [ADDR_W-1:0] new_entry;
   } rrts_op_type;

   // Switch, compaction and commit control for the cell row.
   typedef struct packed {
      logic              commit;
      logic              switch_en;
      logic [SLOT_W-1:0] next_idx;
      logic              remove;
      logic              mark_started;
      logic [SLOT_W-1:0] started_idx;
   } rrts_sw_type;

   localparam rrts_slot_type SLOT_EMPTY = '{
      valid: 1'b0, status: STATUS_READY, ident: '0, entry: '0, started: 1'b0, waits_for: '0
   };

   localparam rrts_slot_type SLOT_BOOT = '{
      valid: 1'b1, status: STATUS_RUNNING, ident: 8'd1, entry: '0, started: 1'b1,
      waits_for: '0
   };

endpackage

@@ design/round_robin_thread_scheduler.sv @@
// Top level of the round robin thread scheduler: control, slot pick and the cell row.
//
// One request beat is one emulated instruction step: a thread call (create, exit,
// join, yield), a halt flag, the cycles it used and the call operands. A beat is taken
// at a clock edge with start high and busy low. The block answers each beat with exactly
// one response beat: rsp_valid is high for one cycle with rsp_data, and the receiver
// must take it then; there is no way to hold it off.
// The quantum register is written through csr_valid/csr_ready/csr_data; ready is
// always high and writes belong between steps.
// A step passes through an execute state, which applies the call, picks the next ready
// slot round robin and compacts the table in the row of slot cells, and then a response
// state that presents the response. busy is low in the response cycle, so the next beat
// can be taken at its end. When the accumulated cycle count is at least twice the
// quantum, the modulo goes through a bit-serial remainder unit in a divide state that
// lies between the execute and response states.
// Synchronous reset leaves thread 1 running in slot 0 with the quantum at 100.
module round_robin_thread_scheduler
   import rrts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  rrts_req_type    req_data,
   output logic            rsp_valid,
   output rrts_rsp_type    rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [QU_W-1:0] csr_data
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_RESP} state_type;

   state_type         state_ff, state_in;
   rrts_req_type      req_ff, req_in;
   logic [QU_W-1:0]   quantum_ff, quantum_in;
   logic [QU_W-1:0]   used_ff, used_in;
   logic [SLOT_W-1:0] run_ff, run_in;
   logic [SLOT_W-1:0] save_ff, save_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]   last_id_ff, last_id_in;
   logic [ID_W-1:0]   created_ff, created_in;
   logic              sw_ff, sw_in;

   rrts_slot_type     slot_q [MAX_THREADS];
   rrts_slot_type     link_out [MAX_THREADS];
   rrts_slot_type     link_in [MAX_THREADS];
   logic [MAX_THREADS-1:0] ready_vec, valid_vec, match_vec, live_mask;

   rrts_op_type       op_cmd;
   rrts_sw_type       sw_cmd;
   rrts_slot_type     run_slot;

   logic              accept, in_exec;
   logic              run_live, halt_path, op_path;
   logic              op_create, op_exit, op_join, op_yield;
   logic              create_ok, join_hit, expired, want_sw, do_sw, remove;
   logic              wrap_once, reduce;
   logic [QU_W-1:0]   q_eff;
   logic [QU_W:0]     used_sum;
   logic [QU_W-1:0]   used_diff;
   logic [QU_W-1:0]   used_sat;
   logic [ID_W-1:0]   next_id;
   logic              pick_found;
   logic [SLOT_W-1:0] pick_idx, pick_cand, run_after;
   logic              rem_load, rem_active;
   logic [QU_W-1:0]   rem_value;

   // Row of slot cells; each passes its updated entry down one place on removal.
   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      if (i == MAX_THREADS - 1) begin : g_top
         assign link_in[i] = SLOT_EMPTY;
      end else begin : g_mid
         assign link_in[i] = link_out[i+1];
      end

      rrts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_W'(i)),
         .op         (op_cmd),
         .sw         (sw_cmd),
         .shift_in   (link_in[i]),
         .shift_out  (link_out[i]),
         .slot_out   (slot_q[i]),
         .ready_out  (ready_vec[i])
      );
   end

   rrts_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .load      (rem_load),
      .dividend  (used_ff),
      .divisor   (q_eff),
      .active    (rem_active),
      .remainder (rem_value)
   );

   always_comb begin
      for (int i = 0; i < MAX_THREADS; i++) begin
         valid_vec[i] = slot_q[i].valid;
         match_vec[i] = slot_q[i].valid && slot_q[i].ident == req_ff.target_id &&
                        SLOT_W'(i) != run_ff;
         live_mask[i] = CNT_W'(i) < count_ff;
      end
   end

   // Round robin pick: the nearest ready slot after the running one, wrapping.
   always_comb begin
      int j;
      pick_found = 1'b0;
      pick_idx   = run_ff;
      pick_cand  = run_ff;
      for (int off = MAX_THREADS - 1; off >= 1; off--) begin
         j = int'(run_ff) + off;
         if (j >= MAX_THREADS) begin
            j = j - MAX_THREADS;
         end
         pick_cand = SLOT_W'(j);
         if (ready_vec[pick_cand]) begin
            pick_found = 1'b1;
            pick_idx   = pick_cand;
         end
      end
   end

   assign run_slot  = slot_q[run_ff];
   assign accept    = start && !busy;
   assign in_exec   = state_ff == S_EXEC;
   assign q_eff     = (quantum_ff == '0) ? QU_W'(1) : quantum_ff;
   assign used_sum  = {1'b0, used_ff} + {{(QU_W - 8 + 1){1'b0}}, req_data.step_cycles};
   assign used_sat  = used_sum[QU_W] ? '1 : used_sum[QU_W-1:0];
   assign used_diff = used_ff - q_eff;

   // A finished running slot ignores the call and the halt flag.
   assign run_live  = run_slot.valid;
   assign halt_path = run_live && req_ff.halted;
   assign op_path   = run_live && !req_ff.halted;
   assign op_create = op_path && req_ff.operation == OP_CREATE;
   assign op_exit   = op_path && req_ff.operation == OP_EXIT;
   assign op_join   = op_path && req_ff.operation == OP_JOIN;
   assign op_yield  = op_path && req_ff.operation == OP_YIELD;
   assign create_ok = op_create && count_ff < CNT_W'(MAX_THREADS);
   assign join_hit  = op_join && (match_vec != '0);
   assign expired   = used_ff >= q_eff;
   assign want_sw   = !run_live || req_ff.halted || op_exit || op_yield ||
                      (op_path && (expired || join_hit || run_slot.status == STATUS_BLOCKED));
   assign do_sw     = want_sw && pick_found;
   assign remove    = op_exit && do_sw;
   assign reduce    = op_path && expired;
   assign wrap_once = used_diff[QU_W-1:0] < q_eff;
   assign rem_load  = in_exec && reduce && !wrap_once;
   assign run_after = (remove && pick_idx > run_ff) ? pick_idx - SLOT_W'(1) : pick_idx;

   // New ids count modulo 256 and never take the value zero.
   always_comb begin
      next_id = last_id_ff + ID_W'(1);
      if (next_id == '0) begin
         next_id = ID_W'(1);
      end
   end

   always_comb begin
      op_cmd.finish    = in_exec && (halt_path || op_exit);
      op_cmd.block     = in_exec && join_hit;
      op_cmd.create    = in_exec && create_ok;
      op_cmd.run_idx   = run_ff;
      op_cmd.finish_id = run_slot.ident;
      op_cmd.target    = req_ff.target_id;
      op_cmd.new_idx   = count_ff[SLOT_W-1:0];
      op_cmd.new_ident = next_id;
      op_cmd.new_entry = req_ff.start_address;

      sw_cmd.commit       = in_exec;
      sw_cmd.switch_en    = in_exec && do_sw;
      sw_cmd.next_idx     = pick_idx;
      sw_cmd.remove       = in_exec && remove;
      sw_cmd.mark_started = (state_ff == S_RESP) && sw_ff;
      sw_cmd.started_idx  = run_ff;
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      quantum_in = quantum_ff;
      used_in    = used_ff;
      run_in     = run_ff;
      save_in    = save_ff;
      count_in   = count_ff;
      last_id_in = last_id_ff;
      created_in = created_ff;
      sw_in      = sw_ff;

      if (csr_valid && csr_ready) begin
         quantum_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE, S_RESP: begin
            if (accept) begin
               req_in   = req_data;
               used_in  = used_sat;
               state_in = S_EXEC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            sw_in      = do_sw;
            save_in    = run_ff;
            run_in     = do_sw ? run_after : run_ff;
            created_in = create_ok ? next_id : '0;
            if (create_ok) begin
               count_in   = count_ff + CNT_W'(1);
               last_id_in = next_id;
            end else if (remove) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = S_RESP;
            if (reduce) begin
               if (wrap_once) begin
                  used_in = used_diff[QU_W-1:0];
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (!rem_active) begin
               used_in  = rem_value;
               state_in = S_RESP;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         req_ff     <= '0;
         quantum_ff <= QUANTUM_RESET;
         used_ff    <= '0;
         run_ff     <= '0;
         save_ff    <= '0;
         count_ff   <= CNT_W'(1);
         last_id_ff <= ID_W'(1);
         created_ff <= '0;
         sw_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         req_ff     <= req_in;
         quantum_ff <= quantum_in;
         used_ff    <= used_in;
         run_ff     <= run_in;
         save_ff    <= save_in;
         count_ff   <= count_in;
         last_id_ff <= last_id_in;
         created_ff <= created_in;
         sw_ff      <= sw_in;
      end
   end

   assign busy      = (state_ff == S_EXEC) || (state_ff == S_DIV);
   assign rsp_valid = state_ff == S_RESP;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_data.switched      = sw_ff;
      rsp_data.save_slot     = sw_ff ? 3'(save_ff) : 3'd0;
      rsp_data.restore_slot  = 3'(run_ff);
      rsp_data.fresh_start   = sw_ff && !run_slot.started;
      rsp_data.entry_address = sw_ff ? run_slot.entry : '0;
      rsp_data.created_id    = created_ff;
      rsp_data.all_finished  = valid_vec == '0;
      rsp_data.live_threads  = 4'(count_ff);
   end

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_EXEC || state_ff == S_DIV))
      else $error("response beat without a step in progress");

   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_THREADS) && (valid_vec & ~live_mask) == '0)
      else $error("valid slot beyond the table count");

   a_switch_lands: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.switched |-> run_slot.valid && run_slot.status == STATUS_RUNNING)
      else $error("switch did not land on a running slot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted step did not make the block busy");

   a_div_to_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && !rem_active |=> rsp_valid)
      else $error("remainder done but no response beat");

endmodule

@@ design/rrts_cell.sv @@
// One thread table slot; hands its updated entry to the lower neighbor for compaction.
module rrts_cell
   import rrts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] cell_index,
   input  rrts_op_type       op,
   input  rrts_sw_type       sw,
   input  rrts_slot_type     shift_in,
   output rrts_slot_type     shift_out,
   output rrts_slot_type     slot_out,
   output logic              ready_out
);

   rrts_slot_type slot_ff, slot_in;
   rrts_slot_type slot_mid, slot_upd;

   // Call effects: finish with wakeup of joiners, join block, create.
   always_comb begin
      slot_mid = slot_ff;
      if (op.finish) begin
         if (cell_index == op.run_idx) begin
            slot_mid.valid = 1'b0;
         end else if (slot_ff.valid && slot_ff.status == STATUS_BLOCKED &&
                      slot_ff.waits_for == op.finish_id) begin
            slot_mid.status = STATUS_READY;
         end
      end
      if (op.block && cell_index == op.run_idx) begin
         slot_mid.status    = STATUS_BLOCKED;
         slot_mid.waits_for = op.target;
      end
      if (op.create && cell_index == op.new_idx) begin
         slot_mid.valid     = 1'b1;
         slot_mid.status    = STATUS_READY;
         slot_mid.ident     = op.new_ident;
         slot_mid.entry     = op.new_entry;
         slot_mid.started   = 1'b0;
         slot_mid.waits_for = '0;
      end
   end

   // Switch effects on top of the call effects.
   always_comb begin
      slot_upd = slot_mid;
      if (sw.switch_en) begin
         if (cell_index == op.run_idx && slot_mid.valid && slot_mid.status == STATUS_RUNNING) begin
            slot_upd.status = STATUS_READY;
         end
         if (cell_index == sw.next_idx) begin
            slot_upd.status = STATUS_RUNNING;
         end
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (sw.commit) begin
         // At and above the removed slot every cell takes its upper neighbor's entry.
         if (sw.remove && cell_index >= op.run_idx) begin
            slot_in = shift_in;
         end else begin
            slot_in = slot_upd;
         end
      end else if (sw.mark_started && cell_index == sw.started_idx) begin
         slot_in.started = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= (cell_index == '0) ? SLOT_BOOT : SLOT_EMPTY;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign shift_out = slot_upd;
   assign slot_out  = slot_ff;
   assign ready_out = slot_mid.valid && slot_mid.status == STATUS_READY;

endmodule

@@ design/rrts_rem.sv @@
// Bit-serial remainder unit that reduces the used quantum count modulo the quantum.
module rrts_rem
   import rrts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  logic [QU_W-1:0] dividend,
   input  logic [QU_W-1:0] divisor,
   output logic            active,
   output logic [QU_W-1:0] remainder
);

   localparam int STEP_W = $clog2(QU_W + 1);

   logic [QU_W-1:0]   rem_ff, rem_in;
   logic [QU_W-1:0]   num_ff, num_in;
   logic [QU_W-1:0]   div_ff, div_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [QU_W:0]     trial;
   logic [QU_W-1:0]   trial_sub;

   assign trial     = {rem_ff, num_ff[QU_W-1]};
   assign trial_sub = trial[QU_W-1:0] - div_ff;

   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = '0;
         num_in = dividend;
         div_in = divisor;
         cnt_in = STEP_W'(QU_W);
      end else if (cnt_ff != '0) begin
         // The partial remainder stays below the divisor, so one bit in needs one subtract.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial_sub;
         end else begin
            rem_in = trial[QU_W-1:0];
         end
         num_in = {num_ff[QU_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

   assign active    = cnt_ff != '0;
   assign remainder = rem_ff;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the round robin thread scheduler with directed and random steps.
module tb
   import rrts_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      bit              is_cfg;
      rrts_req_type    req;
      logic [QU_W-1:0] quantum_val;
      int              gap;
   } sched_cmd_type;

   logic            clock;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   rrts_req_type    req_data = '0;
   logic            rsp_valid;
   rrts_rsp_type    rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [QU_W-1:0] csr_data = QUANTUM_RESET;

   round_robin_thread_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Mirror of the thread table and scheduler registers.
   rrts_slot_type   thr [MAX_THREADS];
   int              run_slot;
   int              thr_count;
   logic [ID_W-1:0] last_id;
   logic [QU_W-1:0] used_cyc;
   logic [QU_W-1:0] quantum_reg;

   sched_cmd_type step_backlog[$];
   rrts_rsp_type  pending_outcomes[$];
   sched_cmd_type cur;
   bit            have_cur = 1'b0;
   int            hold = 0;
   bit            req_beat = 1'b0;
   bit            csr_beat = 1'b0;
   int            failures = 0;
   int            calm_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("round_robin_thread_scheduler: mismatch");
      $finish;
   end

   // Switch to the next ready slot after the running one, wrapping around.
   function automatic bit rotate(output int saved);
      int nxt;
      saved = 0;
      nxt = run_slot;
      for (int i = run_slot + 1; i < thr_count && nxt == run_slot; i++)
         if (thr[i].valid && thr[i].status == STATUS_READY) nxt = i;
      for (int i = 0; i < run_slot && i < thr_count && nxt == run_slot; i++)
         if (thr[i].valid && thr[i].status == STATUS_READY) nxt = i;
      if (nxt == run_slot) return 1'b0;
      if (thr[run_slot].valid && thr[run_slot].status == STATUS_RUNNING)
         thr[run_slot].status = STATUS_READY;
      thr[nxt].status = STATUS_RUNNING;
      saved = run_slot;
      run_slot = nxt;
      return 1'b1;
   endfunction

   // The running thread is done; anyone joined on it may run again.
   function automatic void retire_running();
      logic [ID_W-1:0] id;
      id = thr[run_slot].ident;
      thr[run_slot].valid = 1'b0;
      for (int i = 0; i < thr_count; i++)
         if (thr[i].valid && thr[i].status == STATUS_BLOCKED && thr[i].waits_for == id)
            thr[i].status = STATUS_READY;
   endfunction

   function automatic rrts_rsp_type schedule_step(rrts_req_type r);
      rrts_rsp_type o;
      int q, used, save, old;
      bit sw;
      o = '0;
      sw = 1'b0;
      save = 0;
      q = (quantum_reg == '0) ? 1 : quantum_reg;
      used = used_cyc + r.step_cycles;
      used_cyc = (used > 16'hFFFF) ? 16'hFFFF : used[15:0];
      if (!thr[run_slot].valid) begin
         sw = rotate(save);
      end else if (r.halted) begin
         retire_running();
         sw = rotate(save);
      end else begin
         case (r.operation)
            OP_CREATE: begin
               if (thr_count < MAX_THREADS) begin
                  last_id = last_id + 8'd1;
                  if (last_id == '0) last_id = 8'd1;
                  thr[thr_count] = '{valid: 1'b1, status: STATUS_READY, ident: last_id,
                                     entry: r.start_address, started: 1'b0, waits_for: '0};
                  thr_count++;
                  o.created_id = last_id;
               end
            end
            OP_EXIT: begin
               old = run_slot;
               retire_running();
               sw = rotate(save);
               // The exited entry is only removed when another thread took over.
               if (sw) begin
                  for (int i = old; i + 1 < thr_count; i++) thr[i] = thr[i + 1];
                  thr_count--;
                  thr[thr_count] = SLOT_EMPTY;
                  if (run_slot > old) run_slot--;
               end
            end
            OP_JOIN: begin
               for (int i = 0; i < thr_count; i++) begin
                  if (i != run_slot && thr[i].valid && thr[i].ident == r.target_id) begin
                     thr[run_slot].status = STATUS_BLOCKED;
                     thr[run_slot].waits_for = r.target_id;
                     break;
                  end
               end
            end
            OP_YIELD: begin
               sw = rotate(save);
            end
            default: begin
            end
         endcase
         if (used_cyc >= q) begin
            used_cyc = used_cyc % q;
            if (!sw) sw = rotate(save);
         end else if (!sw && thr[run_slot].status == STATUS_BLOCKED) begin
            sw = rotate(save);
         end
      end
      if (sw) begin
         o.fresh_start = !thr[run_slot].started;
         thr[run_slot].started = 1'b1;
         o.entry_address = thr[run_slot].entry;
         o.save_slot = save[2:0];
      end
      o.switched = sw;
      o.restore_slot = run_slot[2:0];
      o.all_finished = 1'b1;
      for (int i = 0; i < thr_count; i++)
         if (thr[i].valid) o.all_finished = 1'b0;
      o.live_threads = thr_count[3:0];
      return o;
   endfunction

   function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         failures++;
      end
   endfunction

   // Sender idle cycles, with occasional stretches of back-to-back steps.
   function automatic int draw_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 30);
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [7:0] draw_cycles();
      case ($urandom_range(0, 9))
         0: return 8'hFF;
         1: return 8'h00;
         2, 3, 4, 5: return 8'($urandom_range(0, 15));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void push_step(logic [2:0] op, logic halt, logic [7:0] cyc,
                                     logic [15:0] addr, logic [7:0] target);
      sched_cmd_type c;
      c.is_cfg = 1'b0;
      c.quantum_val = '0;
      c.gap = draw_gap();
      c.req = '{operation: op, halted: halt, step_cycles: cyc, start_address: addr,
                target_id: target};
      step_backlog = {step_backlog, c};
   endfunction

   // Random step steered by the mirrored table so that the run keeps live threads.
   function automatic sched_cmd_type draw_step(bit heavy);
      sched_cmd_type c;
      int ready_idx[$];
      int dead, blocked, roll;
      dead = 0;
      blocked = 0;
      for (int i = 0; i < thr_count; i++) begin
         if (!thr[i].valid) dead++;
         else if (i != run_slot && thr[i].status == STATUS_READY) ready_idx = {ready_idx, i};
         else if (i != run_slot && thr[i].status == STATUS_BLOCKED) blocked++;
      end
      c.is_cfg = 1'b0;
      c.quantum_val = '0;
      c.gap = draw_gap();
      c.req.halted = 1'b0;
      c.req.step_cycles = (heavy && $urandom_range(0, 7) != 0) ? 8'hFF : draw_cycles();
      c.req.start_address = 16'($urandom);
      c.req.target_id = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 28) begin
         c.req.operation = OP_CREATE;
      end else if (roll < 52) begin
         c.req.operation = (ready_idx.size() >= 2) ? OP_EXIT : OP_YIELD;
      end else if (roll < 64) begin
         c.req.operation = OP_JOIN;
         // Joins mostly target the running thread or a ready thread; the rest use a random id.
         if (blocked >= 3 || $urandom_range(0, 4) == 0)
            c.req.target_id = thr[run_slot].ident;
         else if (ready_idx.size() != 0 && $urandom_range(0, 3) != 0)
            c.req.target_id = thr[ready_idx[$urandom_range(0, ready_idx.size() - 1)]].ident;
      end else if (roll < 78) begin
         c.req.operation = OP_YIELD;
      end else if (roll < 95) begin
         c.req.operation = OP_NONE;
      end else begin
         case ($urandom_range(0, 2))
            0: c.req.operation = OP_RSVD5;
            1: c.req.operation = OP_RSVD6;
            default: c.req.operation = OP_RSVD7;
         endcase
      end
      // A halted entry is never removed, so halts are kept rare.
      if (dead < 2 && ready_idx.size() >= 2 && $urandom_range(0, 99) < 2)
         c.req.halted = 1'b1;
      return c;
   endfunction

   task automatic run_phase(logic [QU_W-1:0] q, int count, bit heavy);
      sched_cmd_type c;
      c.is_cfg = 1'b1;
      c.req = '0;
      c.quantum_val = q;
      c.gap = 0;
      step_backlog = {step_backlog, c};
      for (int k = 0; k < count; k++) begin
         while (step_backlog.size() >= 2) @(negedge clock);
         step_backlog = {step_backlog, draw_step(heavy)};
      end
   endtask

   // Driver: one request or register beat at a time, changes on the falling edge.
   always @(negedge clock) begin : driver
      logic start_nxt;
      logic csr_nxt;
      start_nxt = start;
      csr_nxt = csr_valid;
      if (req_beat) start_nxt = 1'b0;
      if (csr_beat) csr_nxt = 1'b0;
      if (!reset && !start_nxt && !csr_nxt) begin
         if (!have_cur && step_backlog.size() != 0) begin
            cur = step_backlog.pop_front();
            have_cur = 1'b1;
            hold = cur.gap;
         end
         if (have_cur) begin
            if (cur.is_cfg) begin
               // The quantum only changes once every step has been answered.
               if (pending_outcomes.size() == 0) begin
                  csr_data <= cur.quantum_val;
                  csr_nxt = 1'b1;
                  have_cur = 1'b0;
               end
            end else if (hold > 0) begin
               hold--;
            end else begin
               req_data <= cur.req;
               start_nxt = 1'b1;
               have_cur = 1'b0;
            end
         end
      end
      start <= start_nxt;
      csr_valid <= csr_nxt;
   end

   // Monitor: samples on the rising edge, checks responses, then predicts new steps.
   always @(posedge clock) begin : monitor
      rrts_rsp_type want;
      req_beat = !reset && start && !busy;
      csr_beat = !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t ns: response beat with none expected, got %p", $time, rsp_data);
               failures++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("switched", want.switched, rsp_data.switched);
               check_field("save_slot", want.save_slot, rsp_data.save_slot);
               check_field("restore_slot", want.restore_slot, rsp_data.restore_slot);
               check_field("fresh_start", want.fresh_start, rsp_data.fresh_start);
               check_field("entry_address", want.entry_address, rsp_data.entry_address);
               check_field("created_id", want.created_id, rsp_data.created_id);
               check_field("all_finished", want.all_finished, rsp_data.all_finished);
               check_field("live_threads", want.live_threads, rsp_data.live_threads);
            end
         end
         if (req_beat) begin
            want = schedule_step(req_data);
            pending_outcomes = {pending_outcomes, want};
         end
         if (csr_beat) quantum_reg = csr_data;
      end
   end

   initial begin
      foreach (thr[i]) thr[i] = SLOT_EMPTY;
      thr[0] = SLOT_BOOT;
      run_slot = 0;
      thr_count = 1;
      last_id = 8'd1;
      used_cyc = '0;
      quantum_reg = QUANTUM_RESET;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed steps at the reset quantum.
      push_step(OP_NONE, 1'b0, 8'd0, 16'h0000, 8'h00);
      push_step(OP_CREATE, 1'b0, 8'd1, 16'hFFFF, 8'hFF);
      push_step(OP_CREATE, 1'b0, 8'd2, 16'h0000, 8'h00);
      push_step(OP_YIELD, 1'b0, 8'd0, 16'h1234, 8'h00);
      push_step(OP_JOIN, 1'b0, 8'd3, 16'h0000, 8'd1);
      push_step(OP_JOIN, 1'b0, 8'd3, 16'h0000, 8'd3);
      push_step(OP_JOIN, 1'b0, 8'd3, 16'h0000, 8'd200);
      push_step(OP_EXIT, 1'b0, 8'd4, 16'h0000, 8'h00);
      for (int k = 0; k < 6; k++)
         push_step(OP_CREATE, 1'b0, 8'd0, 16'(16'h1000 * (k + 1)), 8'h00);
      // The table is full here, so this create must fail.
      push_step(OP_CREATE, 1'b0, 8'd0, 16'hABCD, 8'h00);
      push_step(OP_NONE, 1'b0, 8'hFF, 16'h0000, 8'h00);
      push_step(OP_YIELD, 1'b0, 8'hFF, 16'h0000, 8'h00);
      push_step(OP_CREATE, 1'b1, 8'd5, 16'h5555, 8'h00);
      push_step(OP_RSVD5, 1'b0, 8'd1, 16'hFFFF, 8'hFF);
      push_step(OP_RSVD7, 1'b0, 8'd1, 16'hFFFF, 8'hFF);
      push_step(OP_EXIT, 1'b0, 8'd2, 16'h0000, 8'h00);
      for (int k = 0; k < 3; k++)
         push_step(OP_YIELD, 1'b0, 8'd1, 16'h0000, 8'h00);
      // Thread 1 exits and releases the thread joined on it.
      push_step(OP_EXIT, 1'b0, 8'd1, 16'h0000, 8'h00);

      run_phase(16'd1, 200, 1'b0);
      run_phase(16'd0, 150, 1'b0);
      run_phase(16'd65280, 300, 1'b1);
      run_phase(16'hFFFF, 300, 1'b1);
      run_phase(16'd7, 200, 1'b0);
      run_phase(16'($urandom_range(2, 300)), 230, 1'b0);
      run_phase(16'($urandom_range(1, 65280)), 130, 1'b0);
      run_phase(QUANTUM_RESET, 230, 1'b0);
      run_phase(16'($urandom_range(1, 40)), 160, 1'b0);

      // Wind down until the running entry is finished, then steps that must be ignored.
      for (int k = 0; k < 12; k++)
         push_step(OP_EXIT, (k % 3) == 2, draw_cycles(), 16'($urandom), 8'($urandom));
      push_step(OP_CREATE, 1'b0, draw_cycles(), 16'($urandom), 8'($urandom));
      push_step(OP_JOIN, 1'b1, draw_cycles(), 16'($urandom), 8'($urandom));
      push_step(OP_YIELD, 1'b0, draw_cycles(), 16'($urandom), 8'($urandom));
      push_step(OP_CREATE, 1'b1, draw_cycles(), 16'($urandom), 8'($urandom));
      push_step(OP_RSVD6, 1'($urandom_range(0, 1)), draw_cycles(), 16'($urandom),
                8'($urandom));

      while (step_backlog.size() != 0 || have_cur || start || csr_valid ||
             pending_outcomes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (pending_outcomes.size() != 0) begin
         $display("%0t ns: %0d expected response beats never arrived", $time,
                  pending_outcomes.size());
         failures++;
      end
      if (failures == 0)
         $display("round_robin_thread_scheduler: match");
      else
         $display("round_robin_thread_scheduler: mismatch");
      $finish;
   end

endmodule

@@ round_robin_thread_scheduler.f @@
design/rrts_pkg.sv
design/rrts_cell.sv
design/rrts_rem.sv
design/round_robin_thread_scheduler.sv
tb/tb.sv
